// ----- hdl/rccda_pkg.sv -----
package rccda_pkg;

    localparam int RAW_W      = 11;
    localparam int AXIS_W     = 15;
    localparam int STORE_W    = 12;
    localparam int DB_W       = 10;
    localparam int GAIN_W     = 10;
    localparam int CHK_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int N_AXES     = 3;
    // working width of one axis value before shaping
    localparam int X_W        = 17;
    localparam int MAG_W      = 15;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int FRAC_W     = 8;
    localparam int Q_W        = PROD_W - FRAC_W;

    localparam int MID_POINT_DEF = 3000;
    localparam int RAW_BITS_DEF  = 11;

    localparam logic [DB_W-1:0]   DB_RESET      = DB_W'(40);
    localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(256);
    localparam logic [CHK_W-1:0]  MIN_CHK_RESET = CHK_W'(2200);
    localparam logic [CHK_W-1:0]  MAX_CHK_RESET = CHK_W'(3800);
    localparam logic [CHK_W-1:0]  MIN_THR_RESET = CHK_W'(2200);

    localparam logic signed [AXIS_W-1:0] AXIS_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
    localparam logic signed [AXIS_W-1:0] AXIS_MIN = {1'b1, {(AXIS_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND  = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_MIN_CHECK = 3'd2,
        CFG_MAX_CHECK = 3'd3,
        CFG_MIN_THR   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [DB_W-1:0]   deadband;
        logic [GAIN_W-1:0] gain;
        logic [CHK_W-1:0]  min_check;
        logic [CHK_W-1:0]  max_check;
        logic [CHK_W-1:0]  min_thr;
    } cfg_t;

    typedef struct packed {
        logic armed;
        logic flight;
        logic hold;
        logic clear_pid;
        logic bias;
        logic att_clear;
    } arm_status_t;

    // keep only the low bits of a raw channel
    function automatic logic [RAW_W-1:0] mask_raw(input logic [RAW_W-1:0] v, input int bits);
        logic [RAW_W-1:0] m;
        for (int i = 0; i < RAW_W; i++)
        begin
            m[i] = (i < bits) ? v[i] : 1'b0;
        end
        return m;
    endfunction

endpackage

// ----- hdl/rccda_axis_lane.sv -----
module rccda_axis_lane
    import rccda_pkg::*;
#(
    parameter int MID_POINT = MID_POINT_DEF,
    parameter int RAW_BITS  = RAW_BITS_DEF
)
(
    input  logic                     link_active,
    input  logic [RAW_W-1:0]         raw,
    input  logic signed [AXIS_W-1:0] stored,
    input  logic [DB_W-1:0]          deadband,
    input  logic [GAIN_W-1:0]        gain,
    output logic signed [AXIS_W-1:0] cmd,
    output logic                     in_db
);

    logic [RAW_W-1:0]        raw_m;
    logic signed [X_W-1:0]   dbl;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   db_s;
    logic signed [X_W-1:0]   mag_full;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [Q_W-1:0]          q;
    logic                    pos;

    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(2 ** (AXIS_W - 1) - 1);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(2 ** (AXIS_W - 1));

    always_comb
    begin
        raw_m = mask_raw(raw, RAW_BITS);
        dbl   = $signed(X_W'({raw_m, 1'b0}));
        // inactive link reshapes the already conditioned value
        x     = link_active ? (dbl - X_W'(MID_POINT)) : X_W'(stored);
        db_s  = $signed(X_W'(deadband));
        in_db = (x <= db_s) && (x >= -db_s);
        pos   = (x > 0);
        mag_full = pos ? (x - db_s) : (-x - db_s);
        mag   = mag_full[MAG_W-1:0];
        prod  = PROD_W'(mag) * PROD_W'(gain);
        q     = prod[PROD_W-1:FRAC_W];
        if (in_db)
        begin
            cmd = '0;
        end
        else if (pos)
        begin
            cmd = (q > Q_POS_LIM) ? AXIS_MAX : $signed(q[AXIS_W-1:0]);
        end
        else
        begin
            cmd = (q > Q_NEG_LIM) ? AXIS_MIN : $signed(AXIS_W'(0) - q[AXIS_W-1:0]);
        end
    end

endmodule

// ----- hdl/rccda_arm_ctrl.sv -----
module rccda_arm_ctrl
    import rccda_pkg::*;
#(
    parameter int MID_POINT = MID_POINT_DEF
)
(
    input  cfg_t                     cfg,
    input  logic signed [AXIS_W-1:0] cmd [N_AXES],
    input  logic [STORE_W-1:0]       throttle,
    input  logic [STORE_W-1:0]       arm_sw,
    input  logic [STORE_W-1:0]       mode_sw,
    input  logic                     armed,
    input  logic                     flight,
    output arm_status_t              status
);

    localparam logic [STORE_W-1:0] MID_S = STORE_W'(MID_POINT);

    logic signed [X_W-1:0] lo;
    logic signed [X_W-1:0] hi;
    logic                  arm_low;
    logic                  arm_high;
    logic                  arm_now;
    logic                  armed_new;

    always_comb
    begin
        lo = $signed(X_W'(cfg.min_check)) - X_W'(MID_POINT);
        hi = $signed(X_W'(cfg.max_check)) - X_W'(MID_POINT);
        arm_low  = (arm_sw < MID_S);
        arm_high = (arm_sw > MID_S);
        arm_now  = arm_high && (throttle < cfg.min_check) && !armed;
        armed_new = arm_now ? 1'b1 : (arm_low ? 1'b0 : armed);

        status.armed     = armed_new;
        status.clear_pid = arm_low || arm_now;
        // stick gesture: yaw low, roll high, pitch low while switch is off
        status.bias      = arm_low && (X_W'(cmd[2]) < lo) && (X_W'(cmd[0]) > hi)
                           && (X_W'(cmd[1]) < lo);
        status.hold      = !(armed_new && (throttle > cfg.min_thr));
        status.flight    = flight;
        status.att_clear = 1'b0;
        if ((mode_sw > MID_S) && !flight && !armed_new)
        begin
            status.flight    = 1'b1;
            status.att_clear = 1'b1;
        end
        else if ((mode_sw <= MID_S) && flight && !armed_new)
        begin
            status.flight = 1'b0;
        end
    end

endmodule

// ----- hdl/rc_command_deadband_and_arming_top.sv -----
// rc command conditioning with deadband, slope and arm/disarm logic
//
// input channel (in_valid/in_ready) carries one receiver frame per item:
// link flag and six raw channels. output channel (out_valid/out_ready)
// returns one conditioned item per input item, in order.
// cfg channel (cfg_valid/cfg_ready) writes the five tuning registers by
// index; it is always ready and should only be used while the block is idle.
//
// an accepted item is registered and shown on the output in the next cycle.
// one item is accepted per cycle while results are taken; the three axis lanes and
// the arming logic settle in a single pass, the per-lane multiplier sets the path.
// the output register frees as it is taken, so a new item is accepted in
// the same cycle that the previous result leaves.
// when the receiver stalls, the held result stays put and in_ready drops.
// reset restores the register defaults, clears the stored commands,
// sets all detent flags, disarms and selects flight mode.
module rc_command_deadband_and_arming_top
    import rccda_pkg::*;
#(
    parameter int MID_POINT = MID_POINT_DEF,
    parameter int RAW_BITS  = RAW_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     link_active,
    input  logic [RAW_W-1:0]         roll_raw,
    input  logic [RAW_W-1:0]         pitch_raw,
    input  logic [RAW_W-1:0]         yaw_raw,
    input  logic [RAW_W-1:0]         throttle_raw,
    input  logic [RAW_W-1:0]         arm_switch_raw,
    input  logic [RAW_W-1:0]         mode_switch_raw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [AXIS_W-1:0] roll_cmd,
    output logic signed [AXIS_W-1:0] pitch_cmd,
    output logic signed [AXIS_W-1:0] yaw_cmd,
    output logic [STORE_W-1:0]       throttle_cmd,
    output logic [N_AXES-1:0]        detent_flags,
    output logic [N_AXES-1:0]        prior_detent_flags,
    output logic                     is_armed,
    output logic                     hold_pid_reset,
    output logic                     in_flight_mode,
    output logic                     clear_pid_pulse,
    output logic                     bias_request,
    output logic                     attitude_pid_clear
);

    cfg_t                     cfg_reg;
    logic signed [AXIS_W-1:0] axis_reg [N_AXES];
    logic signed [AXIS_W-1:0] axis_next [N_AXES];
    logic [RAW_W-1:0]         raw_arr [N_AXES];
    logic [N_AXES-1:0]        db_next;
    logic [STORE_W-1:0]       throttle_store_reg;
    logic [STORE_W-1:0]       arm_store_reg;
    logic [STORE_W-1:0]       mode_store_reg;
    logic [STORE_W-1:0]       throttle_store_next;
    logic [STORE_W-1:0]       arm_store_next;
    logic [STORE_W-1:0]       mode_store_next;
    logic [N_AXES-1:0]        detent_reg;
    logic                     armed_reg;
    logic                     flight_reg;
    arm_status_t              status;
    logic                     accept;

    // output stage
    logic                     out_valid_reg;
    logic signed [AXIS_W-1:0] roll_reg;
    logic signed [AXIS_W-1:0] pitch_reg;
    logic signed [AXIS_W-1:0] yaw_reg;
    logic [STORE_W-1:0]       throttle_reg;
    logic [N_AXES-1:0]        det_out_reg;
    logic [N_AXES-1:0]        prior_out_reg;
    arm_status_t              status_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign raw_arr[0] = roll_raw;
    assign raw_arr[1] = pitch_raw;
    assign raw_arr[2] = yaw_raw;

    genvar g;
    generate
        for (g = 0; g < N_AXES; g++)
        begin : g_lane
            rccda_axis_lane #(
                .MID_POINT (MID_POINT),
                .RAW_BITS  (RAW_BITS)
            ) u_lane (
                .link_active (link_active),
                .raw         (raw_arr[g]),
                .stored      (axis_reg[g]),
                .deadband    (cfg_reg.deadband),
                .gain        (cfg_reg.gain),
                .cmd         (axis_next[g]),
                .in_db       (db_next[g])
            );
        end
    endgenerate

    always_comb
    begin
        if (link_active)
        begin
            throttle_store_next = STORE_W'({mask_raw(throttle_raw, RAW_BITS), 1'b0});
            arm_store_next      = STORE_W'({mask_raw(arm_switch_raw, RAW_BITS), 1'b0});
            mode_store_next     = STORE_W'({mask_raw(mode_switch_raw, RAW_BITS), 1'b0});
        end
        else
        begin
            throttle_store_next = throttle_store_reg;
            arm_store_next      = arm_store_reg;
            mode_store_next     = mode_store_reg;
        end
    end

    rccda_arm_ctrl #(
        .MID_POINT (MID_POINT)
    ) u_arm (
        .cfg      (cfg_reg),
        .cmd      (axis_next),
        .throttle (throttle_store_next),
        .arm_sw   (arm_store_next),
        .mode_sw  (mode_store_next),
        .armed    (armed_reg),
        .flight   (flight_reg),
        .status   (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband  <= DB_RESET;
            cfg_reg.gain      <= GAIN_RESET;
            cfg_reg.min_check <= MIN_CHK_RESET;
            cfg_reg.max_check <= MAX_CHK_RESET;
            cfg_reg.min_thr   <= MIN_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEADBAND:  cfg_reg.deadband  <= cfg_data[DB_W-1:0];
                CFG_GAIN:      cfg_reg.gain      <= cfg_data[GAIN_W-1:0];
                CFG_MIN_CHECK: cfg_reg.min_check <= cfg_data[CHK_W-1:0];
                CFG_MAX_CHECK: cfg_reg.max_check <= cfg_data[CHK_W-1:0];
                CFG_MIN_THR:   cfg_reg.min_thr   <= cfg_data[CHK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_AXES; i++)
            begin
                axis_reg[i] <= '0;
            end
            throttle_store_reg <= '0;
            arm_store_reg      <= '0;
            mode_store_reg     <= '0;
            detent_reg         <= '1;
            armed_reg          <= 1'b0;
            flight_reg         <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < N_AXES; i++)
                begin
                    axis_reg[i] <= axis_next[i];
                end
                throttle_store_reg <= throttle_store_next;
                arm_store_reg      <= arm_store_next;
                mode_store_reg     <= mode_store_next;
                detent_reg         <= db_next;
                armed_reg          <= status.armed;
                flight_reg         <= status.flight;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            roll_reg      <= axis_next[0];
            pitch_reg     <= axis_next[1];
            yaw_reg       <= axis_next[2];
            throttle_reg  <= throttle_store_next;
            det_out_reg   <= db_next;
            prior_out_reg <= detent_reg;
            status_reg    <= status;
        end
    end

    assign out_valid          = out_valid_reg;
    assign roll_cmd           = roll_reg;
    assign pitch_cmd          = pitch_reg;
    assign yaw_cmd            = yaw_reg;
    assign throttle_cmd       = throttle_reg;
    assign detent_flags       = det_out_reg;
    assign prior_detent_flags = prior_out_reg;
    assign is_armed           = status_reg.armed;
    assign hold_pid_reset     = status_reg.hold;
    assign in_flight_mode     = status_reg.flight;
    assign clear_pid_pulse    = status_reg.clear_pid;
    assign bias_request       = status_reg.bias;
    assign attitude_pid_clear = status_reg.att_clear;

    // an axis inside its deadband always reports zero
    a_detent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && detent_flags[0] |-> roll_cmd == '0)
        else $error("roll in deadband but command not zero");

    // the gyro-bias gesture is only seen on a disarming frame
    a_bias_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bias_request |-> !is_armed && clear_pid_pulse)
        else $error("bias request while armed");

    // a rover-to-flight switch lands in flight mode, disarmed
    a_att_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attitude_pid_clear |-> in_flight_mode && !is_armed)
        else $error("attitude clear without flight mode");

    // while disarmed the pid reset stays asserted
    a_hold_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_armed |-> hold_pid_reset)
        else $error("pid reset released while disarmed");

    // an accepted item is on the output in the next cycle
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item not presented");

    // prior flags follow the detent flags of the item before
    a_prior_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !(in_valid && in_ready)) ##1 (in_valid && in_ready) |=>
        prior_detent_flags == $past(detent_flags, 2))
        else $error("prior detent flags out of step");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rccda_pkg::*;

    localparam int MID         = MID_POINT_DEF;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic             link;
        logic [RAW_W-1:0] roll;
        logic [RAW_W-1:0] pitch;
        logic [RAW_W-1:0] yaw;
        logic [RAW_W-1:0] throttle;
        logic [RAW_W-1:0] arm_sw;
        logic [RAW_W-1:0] mode_sw;
    } frame_t;

    typedef struct {
        logic signed [AXIS_W-1:0] roll;
        logic signed [AXIS_W-1:0] pitch;
        logic signed [AXIS_W-1:0] yaw;
        logic [STORE_W-1:0]       throttle;
        logic [N_AXES-1:0]        detent;
        logic [N_AXES-1:0]        prior_detent;
        arm_status_t              status;
    } cmd_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_DEADBAND;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     link_active = 1'b0;
    logic [RAW_W-1:0]         roll_raw = '0;
    logic [RAW_W-1:0]         pitch_raw = '0;
    logic [RAW_W-1:0]         yaw_raw = '0;
    logic [RAW_W-1:0]         throttle_raw = '0;
    logic [RAW_W-1:0]         arm_switch_raw = '0;
    logic [RAW_W-1:0]         mode_switch_raw = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [AXIS_W-1:0] roll_cmd;
    logic signed [AXIS_W-1:0] pitch_cmd;
    logic signed [AXIS_W-1:0] yaw_cmd;
    logic [STORE_W-1:0]       throttle_cmd;
    logic [N_AXES-1:0]        detent_flags;
    logic [N_AXES-1:0]        prior_detent_flags;
    logic                     is_armed;
    logic                     hold_pid_reset;
    logic                     in_flight_mode;
    logic                     clear_pid_pulse;
    logic                     bias_request;
    logic                     attitude_pid_clear;

    // tuning registers as the block should hold them
    logic [DB_W-1:0]   db_cfg        = DB_RESET;
    logic [GAIN_W-1:0] gain_cfg      = GAIN_RESET;
    logic [CHK_W-1:0]  min_check_cfg = MIN_CHK_RESET;
    logic [CHK_W-1:0]  max_check_cfg = MAX_CHK_RESET;
    logic [CHK_W-1:0]  min_thr_cfg   = MIN_THR_RESET;

    // conditioning state
    logic signed [AXIS_W-1:0] axis_store [N_AXES] = '{default: '0};
    logic [STORE_W-1:0]       throttle_store = '0;
    logic [STORE_W-1:0]       arm_store = '0;
    logic [STORE_W-1:0]       mode_store = '0;
    logic [N_AXES-1:0]        detent_cur = '1;
    logic [N_AXES-1:0]        detent_prev = '1;
    logic                     armed_st = 1'b0;
    logic                     flight_st = 1'b1;

    frame_t      frame_q [$];
    cmd_result_t cmd_q [$];
    frame_t      issue_frame;
    cmd_result_t want_cmd;
    int          frames_queued = 0;
    int          frames_checked = 0;
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    logic        steady = 1'b0;

    rc_command_deadband_and_arming_top dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [AXIS_W-1:0] shape_axis(input int x, output logic in_band);
        longint db;
        longint g;
        longint q;
        db = db_cfg;
        g  = gain_cfg;
        if (x <= db && x >= -db)
        begin
            in_band = 1'b1;
            return '0;
        end
        in_band = 1'b0;
        // pull toward zero by the width, then truncate the Q2.8 product toward zero
        if (x > 0)
            q = ((x - db) * g) / 256;
        else
            q = -(((-(x + db)) * g) / 256);
        if (q > 16383)
            q = 16383;
        else if (q < -16384)
            q = -16384;
        return AXIS_W'(q);
    endfunction

    function automatic cmd_result_t condition_frame(input frame_t f);
        cmd_result_t r;
        int          pre [N_AXES];
        logic [N_AXES-1:0] flags;
        logic        in_band;
        int          lo;
        int          hi;
        lo = int'(min_check_cfg) - MID;
        hi = int'(max_check_cfg) - MID;
        r.status = '0;
        if (f.link)
        begin
            pre[0] = 2 * int'(f.roll) - MID;
            pre[1] = 2 * int'(f.pitch) - MID;
            pre[2] = 2 * int'(f.yaw) - MID;
            // twice an 11 bit raw value always fits in 12 bits
            throttle_store = {f.throttle, 1'b0};
            arm_store      = {f.arm_sw, 1'b0};
            mode_store     = {f.mode_sw, 1'b0};
        end
        else
        begin
            for (int i = 0; i < N_AXES; i++)
                pre[i] = axis_store[i];
        end
        detent_prev = detent_cur;
        for (int i = 0; i < N_AXES; i++)
        begin
            axis_store[i] = shape_axis(pre[i], in_band);
            flags[i] = in_band;
        end
        detent_cur = flags;

        if (arm_store < MID)
        begin
            r.status.clear_pid = 1'b1;
            armed_st = 1'b0;
            if (axis_store[2] < lo && axis_store[0] > hi && axis_store[1] < lo)
                r.status.bias = 1'b1;
        end
        if (arm_store > MID && throttle_store < min_check_cfg && !armed_st)
        begin
            r.status.clear_pid = 1'b1;
            armed_st = 1'b1;
        end
        r.status.hold = !(armed_st && throttle_store > min_thr_cfg);

        // mode only moves while disarmed
        if (mode_store > MID && !flight_st && !armed_st)
        begin
            flight_st = 1'b1;
            r.status.att_clear = 1'b1;
        end
        else if (mode_store <= MID && flight_st && !armed_st)
            flight_st = 1'b0;

        r.roll            = axis_store[0];
        r.pitch           = axis_store[1];
        r.yaw             = axis_store[2];
        r.throttle        = throttle_store;
        r.detent          = detent_cur;
        r.prior_detent    = detent_prev;
        r.status.armed    = armed_st;
        r.status.flight   = flight_st;
        return r;
    endfunction

    task automatic queue_frame(input logic link, input int r, input int p, input int y,
                               input int t, input int a, input int m);
        frame_t f;
        f = {link, RAW_W'(r), RAW_W'(p), RAW_W'(y), RAW_W'(t), RAW_W'(a), RAW_W'(m)};
        frame_q.push_back(f);
        frames_queued++;
    endtask

    function automatic int pick_axis();
        case ($urandom_range(3))
            0: return $urandom_range(0, 2047);
            1: return $urandom_range(1440, 1560);
            2: return $urandom_range(1) ? 2047 : 0;
            default: return $urandom_range(1300, 1700);
        endcase
    endfunction

    function automatic int pick_throttle();
        case ($urandom_range(2))
            0: return $urandom_range(0, 700);
            1: return $urandom_range(700, 1500);
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    // switches sit mostly low or high, sometimes exactly at centre
    function automatic int pick_switch();
        case ($urandom_range(9))
            0: return 1500;
            1, 2, 3, 4: return $urandom_range(0, 1499);
            default: return $urandom_range(1501, 2047);
        endcase
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
        begin
            queue_frame($urandom_range(99) < 85, pick_axis(), pick_axis(), pick_axis(),
                        pick_throttle(), pick_switch(), pick_switch());
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (frames_checked < frames_queued);
        repeat (2) @(posedge clk);
    endtask

    // called just after a rising edge; leaves cfg_valid high for a following write
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEADBAND:  db_cfg = val[DB_W-1:0];
            CFG_GAIN:      gain_cfg = val[GAIN_W-1:0];
            CFG_MIN_CHECK: min_check_cfg = val[CHK_W-1:0];
            CFG_MAX_CHECK: max_check_cfg = val[CHK_W-1:0];
            CFG_MIN_THR:   min_thr_cfg = val[CHK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int db, input int gain, input int min_chk,
                              input int max_chk, input int min_thr);
        write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
        write_reg(CFG_GAIN, CFG_DATA_W'(gain));
        write_reg(CFG_MIN_CHECK, CFG_DATA_W'(min_chk));
        write_reg(CFG_MAX_CHECK, CFG_DATA_W'(max_chk));
        write_reg(CFG_MIN_THR, CFG_DATA_W'(min_thr));
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                cmd_q.push_back(condition_frame({link_active, roll_raw, pitch_raw, yaw_raw,
                                                 throttle_raw, arm_switch_raw,
                                                 mode_switch_raw}));
            if (!in_valid || in_ready)
            begin
                if (frame_q.size() != 0 && (steady || $urandom_range(99) >= 36))
                begin
                    issue_frame = frame_q.pop_front();
                    in_valid        <= 1'b1;
                    link_active     <= issue_frame.link;
                    roll_raw        <= issue_frame.roll;
                    pitch_raw       <= issue_frame.pitch;
                    yaw_raw         <= issue_frame.yaw;
                    throttle_raw    <= issue_frame.throttle;
                    arm_switch_raw  <= issue_frame.arm_sw;
                    mode_switch_raw <= issue_frame.mode_sw;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 36);
        if (rst_n && out_valid && out_ready)
        begin
            frames_checked++;
            if (cmd_q.size() == 0)
            begin
                $display("%0t unexpected item: expected none actual roll_cmd %0d", $time,
                         roll_cmd);
                mismatch_count++;
            end
            else
            begin
                want_cmd = cmd_q.pop_front();
                check_field("roll_cmd", want_cmd.roll, roll_cmd);
                check_field("pitch_cmd", want_cmd.pitch, pitch_cmd);
                check_field("yaw_cmd", want_cmd.yaw, yaw_cmd);
                check_field("throttle_cmd", want_cmd.throttle, throttle_cmd);
                check_field("detent_flags", want_cmd.detent, detent_flags);
                check_field("prior_detent_flags", want_cmd.prior_detent, prior_detent_flags);
                check_field("is_armed", want_cmd.status.armed, is_armed);
                check_field("hold_pid_reset", want_cmd.status.hold, hold_pid_reset);
                check_field("in_flight_mode", want_cmd.status.flight, in_flight_mode);
                check_field("clear_pid_pulse", want_cmd.status.clear_pid, clear_pid_pulse);
                check_field("bias_request", want_cmd.status.bias, bias_request);
                check_field("attitude_pid_clear", want_cmd.status.att_clear,
                            attitude_pid_clear);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        queue_frame(1'b1, 0, 0, 0, 0, 0, 0);                    // all low, disarm, rover
        queue_frame(1'b1, 2047, 2047, 2047, 2047, 2047, 2047);  // all high, throttle blocks arming
        queue_frame(1'b1, 1500, 1500, 1500, 0, 2047, 2047);     // centred sticks, arm
        queue_frame(1'b1, 1520, 1480, 1521, 2047, 2047, 0);     // deadband edges, armed mode held
        queue_frame(1'b1, 1479, 1500, 1500, 1200, 1500, 0);     // arm switch exactly at centre
        queue_frame(1'b0, 0, 0, 0, 0, 0, 0);                    // link lost, stored axes again
        queue_frame(1'b0, 2047, 2047, 2047, 2047, 2047, 2047);
        queue_frame(1'b1, 1500, 1500, 1500, 0, 0, 0);           // disarm, rover
        queue_frame(1'b1, 2047, 0, 0, 0, 0, 2047);              // bias gesture, back to flight
        queue_frame(1'b1, 2047, 0, 0, 0, 0, 1500);              // mode at centre
        queue_frame(1'b1, 1000, 1800, 600, 1000, 1600, 1501);   // mode just above centre
        queue_frame(1'b1, 1521, 1479, 1520, 1099, 1501, 0);     // throttle just under min_check
        queue_frame(1'b1, 1500, 1500, 1500, 1100, 2047, 0);     // throttle equal to min_throttle
        queue_frame(1'b1, 1500, 1500, 1500, 1101, 2047, 0);     // throttle just over
        queue_frame(1'b0, 1234, 321, 1777, 55, 900, 1600);
        queue_random(100);
        wait_idle();

        // steep slope with no deadband: repeated link loss drives axes into saturation
        set_config(0, 1023, 4095, 0, 0);
        queue_frame(1'b1, 2047, 0, 1500, 0, 0, 0);
        repeat (3) queue_frame(1'b0, 0, 2047, 0, 2047, 2047, 2047);
        queue_random(120);
        wait_idle();

        steady <= 1'b1;
        set_config(1000, 0, 0, 4095, 4095);
        queue_random(120);
        wait_idle();
        steady <= 1'b0;

        repeat (2)
        begin
            set_config($urandom_range(0, 200), $urandom_range(128, 1023),
                       $urandom_range(1500, 2800), $urandom_range(3000, 4095),
                       $urandom_range(1500, 3000));
            queue_random(130);
            wait_idle();
        end

        set_config(40, 256, 2200, 3800, 2200);
        queue_random(130);
        wait_idle();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && cmd_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
